[rtl/ccgb_pkg.sv]
`timescale 1ns / 1ps
// ccgb_pkg: shared constants, codes, node record type and the chunk-miss test
// used by the conflict graph builder; depends on nothing
package ccgb_pkg;

   localparam int DEF_MAX_NODES       = 64;
   localparam int DEF_MAX_USERS       = 16;
   localparam int DEF_MAX_FILES       = 16;
   localparam int DEF_MAX_CHUNKS      = 64;
   localparam int DEF_CHUNKS_PER_NODE = 3;

   localparam int USER_W  = 4;
   localparam int FILE_W  = 4;
   localparam int CHUNK_W = 6;
   localparam int COUNT_W = 2;
   localparam int MASK_W  = 64;
   localparam int NUM_W   = 6;
   localparam int DEG_W   = 6;
   localparam int STORED_W = 7;
   localparam int EDGE_W  = 11;
   localparam int STAT_W  = 2;
   localparam int SLOTS   = 3;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } ccgb_action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_RANGE     = 2'd1,
      STAT_BAD_COUNT = 2'd2
   } ccgb_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_WRITE_ROW,
      ST_READ_WAIT,
      ST_REPLY
   } ccgb_state_type;

   typedef struct packed {
      logic [USER_W-1:0]                user;
      logic [FILE_W-1:0]                file;
      logic [SLOTS-1:0][CHUNK_W-1:0]    chunk;
      logic [COUNT_W-1:0]               count;
   } ccgb_node_type;

   // true when some chunk of the node is not cached in the given mask
   function automatic logic node_misses(input logic [MASK_W-1:0] m,
                                        input ccgb_node_type rec);
      logic miss;
      miss = 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
         if (k < int'(rec.count) && !m[rec.chunk[k]]) begin
            miss = 1'b1;
         end
      end
      return miss;
   endfunction

endpackage

[rtl/ccgb_cache_store.sv]
`timescale 1ns / 1ps
// ccgb_cache_store: per user and file chunk mask memory, two read ports,
// with a zeroing sweep after reset; uses ccgb_pkg
module ccgb_cache_store import ccgb_pkg::*; #(
   parameter int ENTRIES = DEF_MAX_USERS * DEF_MAX_FILES,
   parameter int WIDTH   = DEF_MAX_CHUNKS,
   parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   output logic             busy,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr_a,
   output logic [WIDTH-1:0] rdata_a,
   input  logic [AW-1:0]    raddr_b,
   output logic [WIDTH-1:0] rdata_b
);

   logic [WIDTH-1:0] mem [ENTRIES];
   logic [AW-1:0]    clr_ff, clr_in;
   logic             busy_ff, busy_in;
   logic [WIDTH-1:0] rdata_a_ff, rdata_b_ff;

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + AW'(1);
         if (clr_ff == AW'(ENTRIES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign busy    = busy_ff;
   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

[rtl/ccgb_graph_store.sv]
`timescale 1ns / 1ps
// ccgb_graph_store: node record memory and adjacency row plus degree memory,
// one write and one registered read each; uses ccgb_pkg
module ccgb_graph_store import ccgb_pkg::*; #(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int NODE_W    = $clog2(MAX_NODES),
   parameter int ADJ_W     = MAX_NODES + DEG_W
) (
   input  logic             clock,
   input  logic             rec_we,
   input  logic [NODE_W-1:0] rec_waddr,
   input  ccgb_node_type    rec_wdata,
   input  logic [NODE_W-1:0] rec_raddr,
   output ccgb_node_type    rec_rdata,
   input  logic             adj_we,
   input  logic [NODE_W-1:0] adj_waddr,
   input  logic [ADJ_W-1:0] adj_wdata,
   input  logic [NODE_W-1:0] adj_raddr,
   output logic [ADJ_W-1:0] adj_rdata
);

   ccgb_node_type    rec_mem [MAX_NODES];
   logic [ADJ_W-1:0] adj_mem [MAX_NODES];
   ccgb_node_type    rec_q_ff;
   logic [ADJ_W-1:0] adj_q_ff;

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      rec_q_ff <= rec_mem[rec_raddr];
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_waddr] <= adj_wdata;
      end
      adj_q_ff <= adj_mem[adj_raddr];
   end

   assign rec_rdata = rec_q_ff;
   assign adj_rdata = adj_q_ff;

endmodule

[rtl/cache_conflict_graph_builder_unit.sv]
`timescale 1ns / 1ps
// cache_conflict_graph_builder_unit: control and scan pipeline of the conflict
// graph builder; uses ccgb_pkg, ccgb_cache_store, ccgb_graph_store
// add node: one stored node compared per cycle through the node record, cache and
// adjacency memory pipeline
// one word at a time; a result word waits in the output register
// reset: synchronous; after reset the cache store sweeps every entry to zero,
// during which no request word is taken
module cache_conflict_graph_builder_unit import ccgb_pkg::*; #(
   parameter int MAX_NODES       = DEF_MAX_NODES,
   parameter int MAX_USERS       = DEF_MAX_USERS,
   parameter int MAX_FILES       = DEF_MAX_FILES,
   parameter int MAX_CHUNKS      = DEF_MAX_CHUNKS,
   parameter int CHUNKS_PER_NODE = DEF_CHUNKS_PER_NODE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [USER_W-1:0]   req_user,
   input  logic [FILE_W-1:0]   req_file,
   input  logic [MASK_W-1:0]   req_cache_mask,
   input  logic [CHUNK_W-1:0]  req_chunk_first,
   input  logic [CHUNK_W-1:0]  req_chunk_second,
   input  logic [CHUNK_W-1:0]  req_chunk_third,
   input  logic [COUNT_W-1:0]  req_chunk_count,
   input  logic [NUM_W-1:0]    req_node_select,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [NUM_W-1:0]    rsp_node_number,
   output logic [MASK_W-1:0]   rsp_conflict_row,
   output logic [DEG_W-1:0]    rsp_node_degree,
   output logic [STORED_W-1:0] rsp_nodes_stored,
   output logic [EDGE_W-1:0]   rsp_edge_total,
   output logic [STAT_W-1:0]   rsp_status
);

   localparam int ENTRIES  = MAX_USERS * MAX_FILES;
   localparam int CACHE_AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int NODE_W   = $clog2(MAX_NODES);
   localparam int NT_W     = $clog2(MAX_NODES + 1);
   localparam int ADJ_W    = MAX_NODES + DEG_W;

   ccgb_state_type    state_ff, state_in;
   ccgb_action_type   act_ff, act_in;
   ccgb_node_type     new_ff, new_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [NUM_W-1:0]  sel_ff, sel_in;

   logic [NT_W-1:0]   total_ff, total_in;
   logic [EDGE_W-1:0] edge_ff, edge_in;
   logic [NT_W-1:0]   iss_ff, iss_in;
   logic              a_valid_ff, a_valid_in;
   logic [NODE_W-1:0] a_idx_ff, a_idx_in;
   logic              b_valid_ff, b_valid_in;
   logic [NODE_W-1:0] b_idx_ff, b_idx_in;
   ccgb_node_type     b_rec_ff, b_rec_in;
   logic [MAX_NODES-1:0] row_acc_ff, row_acc_in;
   logic [DEG_W-1:0]  deg_acc_ff, deg_acc_in;

   logic [NUM_W-1:0]  res_num_ff, res_num_in;
   logic [MAX_NODES-1:0] res_row_ff, res_row_in;
   logic [DEG_W-1:0]  res_deg_ff, res_deg_in;
   ccgb_status_type   res_stat_ff, res_stat_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]  rsp_num_ff, rsp_num_in;
   logic [MASK_W-1:0] rsp_row_ff, rsp_row_in;
   logic [DEG_W-1:0]  rsp_deg_ff, rsp_deg_in;
   logic [STORED_W-1:0] rsp_stored_ff, rsp_stored_in;
   logic [EDGE_W-1:0] rsp_edge_ff, rsp_edge_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;

   logic                  cache_busy;
   logic                  cache_we;
   logic [CACHE_AW-1:0]   cache_waddr, cache_raddr_a, cache_raddr_b;
   logic [MAX_CHUNKS-1:0] cache_rdata_a, cache_rdata_b;
   logic [MASK_W-1:0]     mask_a, mask_b;

   logic                  rec_we;
   logic [NODE_W-1:0]     rec_waddr, rec_raddr;
   ccgb_node_type         rec_rdata;
   logic                  adj_we;
   logic [NODE_W-1:0]     adj_waddr, adj_raddr;
   logic [ADJ_W-1:0]      adj_wdata, adj_rdata;

   logic                  accept;
   logic                  in_range;
   logic                  conflict;
   logic [NODE_W-1:0]     new_idx;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || cache_busy;
   assign new_idx   = total_ff[NODE_W-1:0];
   assign in_range  = (int'(new_ff.user) < MAX_USERS) && (int'(new_ff.file) < MAX_FILES);
   assign mask_a    = MASK_W'(cache_rdata_a);
   assign mask_b    = MASK_W'(cache_rdata_b);
   assign conflict  = node_misses(mask_a, b_rec_ff) || node_misses(mask_b, new_ff);

   ccgb_cache_store #(
      .ENTRIES (ENTRIES),
      .WIDTH   (MAX_CHUNKS),
      .AW      (CACHE_AW)
   ) u_cache (
      .clock   (clock),
      .reset   (reset),
      .busy    (cache_busy),
      .we      (cache_we),
      .waddr   (cache_waddr),
      .wdata   (mask_ff[MAX_CHUNKS-1:0]),
      .raddr_a (cache_raddr_a),
      .rdata_a (cache_rdata_a),
      .raddr_b (cache_raddr_b),
      .rdata_b (cache_rdata_b)
   );

   ccgb_graph_store #(
      .MAX_NODES (MAX_NODES),
      .NODE_W    (NODE_W),
      .ADJ_W     (ADJ_W)
   ) u_graph (
      .clock     (clock),
      .rec_we    (rec_we),
      .rec_waddr (rec_waddr),
      .rec_wdata (new_ff),
      .rec_raddr (rec_raddr),
      .rec_rdata (rec_rdata),
      .adj_we    (adj_we),
      .adj_waddr (adj_waddr),
      .adj_wdata (adj_wdata),
      .adj_raddr (adj_raddr),
      .adj_rdata (adj_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      new_in      = new_ff;
      mask_in     = mask_ff;
      sel_in      = sel_ff;
      total_in    = total_ff;
      edge_in     = edge_ff;
      iss_in      = iss_ff;
      a_valid_in  = 1'b0;
      a_idx_in    = a_idx_ff;
      b_valid_in  = 1'b0;
      b_idx_in    = a_idx_ff;
      b_rec_in    = rec_rdata;
      row_acc_in  = row_acc_ff;
      deg_acc_in  = deg_acc_ff;
      res_num_in  = res_num_ff;
      res_row_in  = res_row_ff;
      res_deg_in  = res_deg_ff;
      res_stat_in = res_stat_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_num_in    = rsp_num_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_deg_in    = rsp_deg_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_edge_in   = rsp_edge_ff;
      rsp_stat_in   = rsp_stat_ff;
      cache_we      = 1'b0;
      cache_waddr   = CACHE_AW'(int'(new_ff.user) * MAX_FILES + int'(new_ff.file));
      cache_raddr_a = CACHE_AW'(int'(new_ff.user) * MAX_FILES + int'(rec_rdata.file));
      cache_raddr_b = CACHE_AW'(int'(rec_rdata.user) * MAX_FILES + int'(new_ff.file));
      rec_we    = 1'b0;
      rec_waddr = new_idx;
      rec_raddr = iss_ff[NODE_W-1:0];
      adj_we    = 1'b0;
      adj_waddr = b_idx_ff;
      adj_wdata = {adj_rdata[ADJ_W-1:MAX_NODES] + DEG_W'(1),
                   adj_rdata[MAX_NODES-1:0] | (MAX_NODES'(1) << new_idx)};
      adj_raddr = a_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in        = ccgb_action_type'(req_action);
               new_in.user   = req_user;
               new_in.file   = req_file;
               new_in.chunk  = {req_chunk_third, req_chunk_second, req_chunk_first};
               new_in.count  = req_chunk_count;
               mask_in       = req_cache_mask;
               sel_in        = req_node_select;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_num_in  = '0;
            res_row_in  = '0;
            res_deg_in  = '0;
            res_stat_in = STAT_OK;
            state_in    = ST_REPLY;
            case (act_ff)
               ACT_WRITE: begin
                  if (in_range) begin
                     cache_we = 1'b1;
                  end else begin
                     res_stat_in = STAT_RANGE;
                  end
               end
               ACT_ADD: begin
                  if (new_ff.count == '0 || int'(new_ff.count) > CHUNKS_PER_NODE) begin
                     res_stat_in = STAT_BAD_COUNT;
                  end else if (!in_range || total_ff == NT_W'(MAX_NODES)) begin
                     res_stat_in = STAT_RANGE;
                  end else begin
                     rec_we     = 1'b1;
                     iss_in     = '0;
                     row_acc_in = '0;
                     deg_acc_in = '0;
                     state_in   = ST_SCAN;
                  end
               end
               ACT_READ: begin
                  if (int'(sel_ff) >= int'(total_ff)) begin
                     res_stat_in = STAT_RANGE;
                  end else begin
                     adj_raddr = sel_ff[NODE_W-1:0];
                     state_in  = ST_READ_WAIT;
                  end
               end
               ACT_CLEAR: begin
                  total_in = '0;
                  edge_in  = '0;
               end
               default: begin
                  res_stat_in = STAT_OK;
               end
            endcase
         end
         ST_SCAN: begin
            // issue stage
            if (iss_ff < total_ff) begin
               a_valid_in = 1'b1;
               a_idx_in   = iss_ff[NODE_W-1:0];
               iss_in     = iss_ff + NT_W'(1);
            end
            // record available, cache and adjacency reads go out
            b_valid_in = a_valid_ff;
            // compare and update stage
            if (b_valid_ff && conflict) begin
               adj_we     = 1'b1;
               row_acc_in = row_acc_ff | (MAX_NODES'(1) << b_idx_ff);
               deg_acc_in = deg_acc_ff + DEG_W'(1);
               edge_in    = edge_ff + EDGE_W'(1);
            end
            if (iss_ff == total_ff && !a_valid_ff && !b_valid_ff) begin
               state_in = ST_WRITE_ROW;
            end
         end
         ST_WRITE_ROW: begin
            adj_we      = 1'b1;
            adj_waddr   = new_idx;
            adj_wdata   = {deg_acc_ff, row_acc_ff};
            res_num_in  = NUM_W'(total_ff);
            res_row_in  = row_acc_ff;
            res_deg_in  = deg_acc_ff;
            res_stat_in = STAT_OK;
            total_in    = total_ff + NT_W'(1);
            state_in    = ST_REPLY;
         end
         ST_READ_WAIT: begin
            res_num_in  = sel_ff;
            res_row_in  = adj_rdata[MAX_NODES-1:0];
            res_deg_in  = adj_rdata[ADJ_W-1:MAX_NODES];
            res_stat_in = STAT_OK;
            state_in    = ST_REPLY;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_num_in    = res_num_ff;
               rsp_row_in    = MASK_W'(res_row_ff);
               rsp_deg_in    = res_deg_ff;
               rsp_stored_in = STORED_W'(total_ff);
               rsp_edge_in   = edge_ff;
               rsp_stat_in   = res_stat_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         edge_ff      <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         edge_ff      <= edge_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      new_ff        <= new_in;
      mask_ff       <= mask_in;
      sel_ff        <= sel_in;
      iss_ff        <= iss_in;
      a_idx_ff      <= a_idx_in;
      b_idx_ff      <= b_idx_in;
      b_rec_ff      <= b_rec_in;
      row_acc_ff    <= row_acc_in;
      deg_acc_ff    <= deg_acc_in;
      res_num_ff    <= res_num_in;
      res_row_ff    <= res_row_in;
      res_deg_ff    <= res_deg_in;
      res_stat_ff   <= res_stat_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_deg_ff    <= rsp_deg_in;
      rsp_stored_ff <= rsp_stored_in;
      rsp_edge_ff   <= rsp_edge_in;
      rsp_stat_ff   <= rsp_stat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_node_number  = rsp_num_ff;
   assign rsp_conflict_row = rsp_row_ff;
   assign rsp_node_degree  = rsp_deg_ff;
   assign rsp_nodes_stored = rsp_stored_ff;
   assign rsp_edge_total   = rsp_edge_ff;
   assign rsp_status       = rsp_stat_ff;

endmodule

[tb/sv/cache_conflict_graph_builder_unit_tb.sv]
`timescale 1ns / 1ps
// cache_conflict_graph_builder_unit_tb: self-checking bench for the conflict graph
// builder; directed table then random words, checked by a local graph model
// depends on ccgb_pkg and cache_conflict_graph_builder_unit
module cache_conflict_graph_builder_unit_tb;
   import ccgb_pkg::*;

   localparam int RANDOM_WORDS = 1600;
   localparam int DOG_LIMIT    = 5000;

   typedef struct {
      ccgb_action_type   act;
      logic [USER_W-1:0]  user;
      logic [FILE_W-1:0]  file;
      logic [MASK_W-1:0]  mask;
      logic [CHUNK_W-1:0] c0, c1, c2;
      logic [COUNT_W-1:0] cnt;
      logic [NUM_W-1:0]   sel;
   } graph_req_type;

   typedef struct {
      logic [NUM_W-1:0]    num;
      logic [MASK_W-1:0]   row;
      logic [DEG_W-1:0]    deg;
      logic [STORED_W-1:0] stored;
      logic [EDGE_W-1:0]   edges;
      ccgb_status_type     status;
   } graph_rsp_type;

   typedef struct {
      graph_req_type req;
      bit            typed;
      graph_rsp_type rsp;
   } table_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_action = 0;
   logic [USER_W-1:0] req_user = 0;
   logic [FILE_W-1:0] req_file = 0;
   logic [MASK_W-1:0] req_cache_mask = 0;
   logic [CHUNK_W-1:0] req_chunk_first = 0, req_chunk_second = 0, req_chunk_third = 0;
   logic [COUNT_W-1:0] req_chunk_count = 0;
   logic [NUM_W-1:0] req_node_select = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [NUM_W-1:0] rsp_node_number;
   logic [MASK_W-1:0] rsp_conflict_row;
   logic [DEG_W-1:0] rsp_node_degree;
   logic [STORED_W-1:0] rsp_nodes_stored;
   logic [EDGE_W-1:0] rsp_edge_total;
   logic [STAT_W-1:0] rsp_status;

   cache_conflict_graph_builder_unit i_dut (.*);

   always #6 clock = ~clock;

   // graph model state
   logic [MASK_W-1:0] cached [0:255];
   ccgb_node_type     nodes [0:63];
   logic [MASK_W-1:0] adj [0:63];
   logic [DEG_W-1:0]  degs [0:63];
   int                node_cnt;
   logic [EDGE_W-1:0] edge_cnt;

   graph_rsp_type pending_rsp [$];
   table_row_type dir_rows [$];
   int  mismatches = 0;
   int  words_taken = 0;
   int  idle_cycles = 0;

   function automatic bit chunk_miss(ccgb_node_type n, logic [USER_W-1:0] u);
      logic [MASK_W-1:0] m;
      bit miss;
      m = cached[{u, n.file}];
      miss = 0;
      for (int k = 0; k < SLOTS; k++)
         if (k < int'(n.count) && !m[n.chunk[k]]) miss = 1;
      return miss;
   endfunction

   function automatic void graph_clear();
      for (int i = 0; i < 64; i++) begin
         adj[i] = '0;
         degs[i] = '0;
      end
      node_cnt = 0;
      edge_cnt = '0;
   endfunction

   function automatic graph_rsp_type graph_apply(graph_req_type r);
      graph_rsp_type o;
      ccgb_node_type n;
      o = '{num: 0, row: 0, deg: 0, stored: 0, edges: 0, status: STAT_OK};
      case (r.act)
         ACT_WRITE: cached[{r.user, r.file}] = r.mask;
         ACT_ADD: begin
            if (r.cnt == 0) begin
               o.status = STAT_BAD_COUNT;
            end else if (node_cnt >= 64) begin
               o.status = STAT_RANGE;
            end else begin
               n.user = r.user;
               n.file = r.file;
               n.chunk[0] = r.c0;
               n.chunk[1] = r.c1;
               n.chunk[2] = r.c2;
               n.count = r.cnt;
               nodes[node_cnt] = n;
               adj[node_cnt] = '0;
               degs[node_cnt] = '0;
               for (int e = 0; e < node_cnt; e++) begin
                  if (chunk_miss(nodes[e], r.user) || chunk_miss(n, nodes[e].user)) begin
                     adj[node_cnt][e] = 1'b1;
                     adj[e][node_cnt] = 1'b1;
                     degs[node_cnt] = degs[node_cnt] + 1'b1;
                     degs[e] = degs[e] + 1'b1;
                     edge_cnt = edge_cnt + 1'b1;
                  end
               end
               o.num = NUM_W'(node_cnt);
               o.row = adj[node_cnt];
               o.deg = degs[node_cnt];
               node_cnt++;
            end
         end
         ACT_READ: begin
            if (r.sel >= node_cnt) begin
               o.status = STAT_RANGE;
            end else begin
               o.num = r.sel;
               o.row = adj[r.sel];
               o.deg = degs[r.sel];
            end
         end
         default: graph_clear();
      endcase
      o.stored = STORED_W'(node_cnt);
      o.edges = edge_cnt;
      return o;
   endfunction

   function automatic graph_req_type mk(ccgb_action_type a, int u, int f, logic [63:0] m,
                                        int c0, int c1, int c2, int cnt, int sel);
      graph_req_type r;
      r.act = a; r.user = USER_W'(u); r.file = FILE_W'(f); r.mask = m;
      r.c0 = CHUNK_W'(c0); r.c1 = CHUNK_W'(c1); r.c2 = CHUNK_W'(c2);
      r.cnt = COUNT_W'(cnt); r.sel = NUM_W'(sel);
      return r;
   endfunction

   function automatic graph_rsp_type rs(int num, logic [63:0] row, int deg, int st, int ed,
                                        ccgb_status_type s);
      graph_rsp_type o;
      o.num = NUM_W'(num); o.row = row; o.deg = DEG_W'(deg);
      o.stored = STORED_W'(st); o.edges = EDGE_W'(ed); o.status = s;
      return o;
   endfunction

   function automatic void add_row(graph_req_type r, bit typed, graph_rsp_type o);
      table_row_type row;
      row.req = r;
      row.typed = typed;
      row.rsp = o;
      dir_rows = {dir_rows, row};
   endfunction

   function automatic graph_req_type random_req();
      graph_req_type r;
      int pick;
      r.user = USER_W'($urandom);
      r.file = FILE_W'($urandom);
      r.c0 = CHUNK_W'($urandom);
      r.c1 = CHUNK_W'($urandom);
      r.c2 = CHUNK_W'($urandom);
      pick = $urandom_range(0, 19);
      r.cnt = COUNT_W'((pick == 0) ? 0 : 1 + pick % 3);
      case ($urandom_range(0, 3))
         0: r.mask = '1;
         1: r.mask = ~(64'd1 << $urandom_range(0, 63)) & ~(64'd1 << $urandom_range(0, 63));
         2: r.mask = {$urandom, $urandom};
         default: r.mask = '0;
      endcase
      r.sel = NUM_W'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, node_cnt));
      pick = $urandom_range(0, 299);
      if ((node_cnt == 64 && pick < 30) || pick < 2) r.act = ACT_CLEAR;
      else if (pick < 80) r.act = ACT_WRITE;
      else if (pick < 230) r.act = ACT_ADD;
      else r.act = ACT_READ;
      return r;
   endfunction

   task automatic send_word(graph_req_type r, bit typed, graph_rsp_type t);
      graph_rsp_type p;
      req_action <= r.act;
      req_user <= r.user;
      req_file <= r.file;
      req_cache_mask <= r.mask;
      req_chunk_first <= r.c0;
      req_chunk_second <= r.c1;
      req_chunk_third <= r.c2;
      req_chunk_count <= r.cnt;
      req_node_select <= r.sel;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      p = graph_apply(r);
      if (typed) p = t;
      pending_rsp = {pending_rsp, p};
   endtask

   // driver
   initial begin
      int burst;
      for (int i = 0; i < 256; i++) cached[i] = '0;
      graph_clear();
      add_row(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 1, 0), 1, rs(0, 0, 0, 0, 0, STAT_RANGE));
      add_row(mk(ACT_ADD, 3, 3, 0, 1, 2, 3, 0, 0), 1, rs(0, 0, 0, 0, 0, STAT_BAD_COUNT));
      add_row(mk(ACT_ADD, 0, 0, 0, 63, 0, 5, 3, 0), 1, rs(0, 0, 0, 1, 0, STAT_OK));
      add_row(mk(ACT_ADD, 15, 15, 0, 0, 9, 9, 1, 0), 1, rs(1, 64'h1, 1, 2, 1, STAT_OK));
      add_row(mk(ACT_WRITE, 15, 15, '1, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 2, 1, STAT_OK));
      add_row(mk(ACT_WRITE, 0, 15, '1, 0, 0, 0, 0, 0), 0, rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_WRITE, 15, 0, '1, 0, 0, 0, 0, 0), 0, rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_WRITE, 0, 0, '1, 0, 0, 0, 0, 0), 0, rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_ADD, 0, 0, 0, 0, 63, 7, 2, 0), 0, rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_ADD, 15, 0, 0, 63, 63, 63, 3, 0), 0, rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_ADD, 3, 7, 0, 10, 63, 63, 1, 0), 0, rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_WRITE, 15, 15, 64'h8000_0000_0000_0001, 0, 0, 0, 0, 0), 0,
              rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_ADD, 15, 15, 0, 0, 63, 1, 2, 0), 0, rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 1), 0, rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 63), 0, rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, 0, STAT_OK));
      add_row(mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, 0, STAT_RANGE));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      burst = $urandom_range(1, 20);
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         send_word(random_req(), 0, rs(0, 0, 0, 0, 0, STAT_OK));
         if (--burst == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst = $urandom_range(1, 20);
         end
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0)
         $display("cache_conflict_graph_builder_unit regression: pass");
      else
         $display("cache_conflict_graph_builder_unit regression: fail");
      $finish;
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      logic [15:0] pat;
      int hold;
      bit held;
      pat = '0;
      hold = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (!held && words_taken >= 400) begin
            held = 1;
            hold = 500;
         end
         if ($urandom_range(0, 63) == 0)
            pat = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
         pat = {pat[14:0], pat[15]};
         if (hold > 0) hold--;
         rsp_stall <= (hold > 0) || pat[0];
      end
   end

   // result check and watchdog
   always @(posedge clock) begin
      graph_rsp_type e;
      if (!reset) begin
         if (req_valid && !req_stall) words_taken <= words_taken + 1;
         idle_cycles <= ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) ? 0
                        : idle_cycles + 1;
         if (idle_cycles >= DOG_LIMIT) begin
            $display("cache_conflict_graph_builder_unit regression: fail");
            $finish;
         end
      end
      if (rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected result word at %0t", $realtime);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_node_number !== e.num || rsp_conflict_row !== e.row
                || rsp_node_degree !== e.deg || rsp_nodes_stored !== e.stored
                || rsp_edge_total !== e.edges || rsp_status !== e.status) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) begin
                  $display("exp num %0d row %h deg %0d n %0d e %0d st %0d",
                     e.num, e.row, e.deg, e.stored, e.edges, e.status);
                  $display("got num %0d row %h deg %0d n %0d e %0d st %0d",
                     rsp_node_number, rsp_conflict_row, rsp_node_degree,
                     rsp_nodes_stored, rsp_edge_total, rsp_status);
               end
            end
         end
      end
   end

endmodule

[files.f]
rtl/ccgb_pkg.sv
rtl/ccgb_cache_store.sv
rtl/ccgb_graph_store.sv
rtl/cache_conflict_graph_builder_unit.sv
tb/sv/cache_conflict_graph_builder_unit_tb.sv
